[src/rv64_pkg.sv]
// Package for the RV64I executor: payload structs, opcode and status codes.
// No dependencies; used by every module in src.
package rv64_pkg;

  typedef struct packed {
    logic        op;
    logic [31:0] instruction_word;
    logic        check_breakpoint;
    logic [63:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] mem_address;
    logic [63:0] mem_write_data;
    logic [7:0]  byte_mask;
    logic [63:0] next_pc;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic        misaligned;
    logic [63:0] retired_count;
  } out_item_t;

  localparam logic [2:0] ST_RETIRED = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_STORE   = 3'd2;
  localparam logic [2:0] ST_BREAK   = 3'd3;
  localparam logic [2:0] ST_PC_MIS  = 3'd4;

  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMMW = 7'h1b;
  localparam logic [6:0] OPC_OPW    = 7'h3b;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_BP_EN    = 2'd1;
  localparam logic [1:0] CFG_BP_ADDR  = 2'd2;

  // Architectural state handed from the state holder to the execute logic.
  typedef struct packed {
    logic [63:0] pc;
    logic [63:0] retired;
    logic        load_waiting;
    logic [4:0]  load_dest;
    logic [2:0]  load_kind;
    logic [2:0]  load_byte_offset;
    logic        bp_enable;
    logic [63:0] bp_address;
  } arch_state_t;

  // Update produced by execute for one transfer.
  typedef struct packed {
    logic        valid;
    logic [63:0] pc;
    logic [63:0] retired;
    logic        load_waiting;
    logic [4:0]  load_dest;
    logic [2:0]  load_kind;
    logic [2:0]  load_byte_offset;
    logic        reg_we;
    logic [4:0]  reg_idx;
    logic [63:0] reg_val;
  } arch_update_t;

endpackage

[src/rv64_exec.sv]
// Combinational execute logic: decodes one item against the current state.
// Depends on rv64_pkg.
module rv64_exec (
  input  rv64_pkg::in_item_t     item,
  input  rv64_pkg::arch_state_t  st,
  input  logic [63:0]            rs1_val,
  input  logic [63:0]            rs2_val,
  output rv64_pkg::arch_update_t upd,
  output rv64_pkg::out_item_t    res
);
  import rv64_pkg::*;

  logic [31:0] w;
  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt;
  logic [63:0] a, b, immi, imms, immu, immb, immj, pc, npc, rr, addr, lres, ldsh;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic [31:0] wres;
  logic        wr, take, lt_s, lt_u;
  logic [63:0] lt_s_i, lt_u_i;
  logic [5:0]  lsh;
  logic [2:0]  lane;

  always_comb begin
    w = item.instruction_word;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    alt = w[30];
    a = rs1_val;
    b = rs2_val;
    pc = st.pc;
    immi = {{52{w[31]}}, w[31:20]};
    imms = {{52{w[31]}}, w[31:25], w[11:7]};
    immu = {{32{w[31]}}, w[31:12], 12'h000};
    immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    lt_s = $signed(a) < $signed(b);
    lt_u = a < b;
    lt_s_i = {63'd0, $signed(a) < $signed(immi)};
    lt_u_i = {63'd0, a < immi};

    upd = '0;
    upd.pc = st.pc;
    upd.retired = st.retired;
    upd.load_waiting = st.load_waiting;
    upd.load_dest = st.load_dest;
    upd.load_kind = st.load_kind;
    upd.load_byte_offset = st.load_byte_offset;
    res = '0;
    res.retired_count = st.retired;
    res.next_pc = st.pc;
    npc = pc + 64'd4;
    rr = '0;
    wr = 1'b0;
    take = 1'b0;
    addr = '0;
    wres = '0;
    sh6 = '0;
    sh5 = '0;
    lane = '0;
    lsh = '0;
    ldsh = '0;
    lres = '0;

    if (item.op) begin
      // Load data return.
      lsh = {st.load_byte_offset, 3'b000};
      case (st.load_kind)
        3'd0, 3'd4: lsh = {st.load_byte_offset, 3'b000};
        3'd1, 3'd5: lsh = {st.load_byte_offset & 3'b110, 3'b000};
        3'd2, 3'd6: lsh = {st.load_byte_offset & 3'b100, 3'b000};
        default:    lsh = '0;
      endcase
      ldsh = item.load_data >> lsh;
      case (st.load_kind)
        3'd0:    lres = {{56{ldsh[7]}}, ldsh[7:0]};
        3'd1:    lres = {{48{ldsh[15]}}, ldsh[15:0]};
        3'd2:    lres = {{32{ldsh[31]}}, ldsh[31:0]};
        3'd4:    lres = {56'd0, ldsh[7:0]};
        3'd5:    lres = {48'd0, ldsh[15:0]};
        3'd6:    lres = {32'd0, ldsh[31:0]};
        default: lres = item.load_data;
      endcase
      upd.valid = st.load_waiting;
      upd.load_waiting = 1'b0;
      upd.retired = st.retired + 64'd1;
      upd.reg_we = st.load_dest != 5'd0;
      upd.reg_idx = st.load_dest;
      upd.reg_val = lres;
      res.status = ST_RETIRED;
      res.next_pc = st.pc;
      res.retired_count = upd.retired;
      if (st.load_dest != 5'd0) begin
        res.dest_index = st.load_dest;
        res.dest_value = lres;
      end
    end else begin
      upd.valid = !st.load_waiting;
      if (pc[1:0] != 2'b00) begin
        res.status = ST_PC_MIS;
      end else if (item.check_breakpoint && st.bp_enable && pc == st.bp_address) begin
        res.status = ST_BREAK;
      end else begin
        case (opc)
          OPC_OPIMM: begin
            wr = 1'b1;
            sh6 = w[25:20];
            case (f3)
              3'd0:    rr = a + immi;
              3'd1:    rr = a << sh6;
              3'd2:    rr = lt_s_i;
              3'd3:    rr = lt_u_i;
              3'd4:    rr = a ^ immi;
              3'd5:    rr = alt ? 64'($signed(a) >>> sh6) : a >> sh6;
              3'd6:    rr = a | immi;
              default: rr = a & immi;
            endcase
          end
          OPC_OP: begin
            wr = 1'b1;
            sh6 = b[5:0];
            case (f3)
              3'd0:    rr = alt ? a - b : a + b;
              3'd1:    rr = a << sh6;
              3'd2:    rr = {63'd0, lt_s};
              3'd3:    rr = {63'd0, lt_u};
              3'd4:    rr = a ^ b;
              3'd5:    rr = alt ? 64'($signed(a) >>> sh6) : a >> sh6;
              3'd6:    rr = a | b;
              default: rr = a & b;
            endcase
          end
          OPC_OPIMMW, OPC_OPW: begin
            sh5 = (opc == OPC_OPIMMW) ? w[24:20] : b[4:0];
            wr = 1'b1;
            case (f3)
              3'd0: begin
                if (opc == OPC_OPIMMW) wres = a[31:0] + immi[31:0];
                else wres = alt ? a[31:0] - b[31:0] : a[31:0] + b[31:0];
              end
              3'd1: wres = a[31:0] << sh5;
              3'd5: wres = alt ? 32'($signed(a[31:0]) >>> sh5) : a[31:0] >> sh5;
              default: wr = 1'b0;
            endcase
            rr = {{32{wres[31]}}, wres};
          end
          OPC_LUI: begin
            wr = 1'b1;
            rr = immu;
          end
          OPC_AUIPC: begin
            wr = 1'b1;
            rr = pc + immu;
          end
          OPC_JAL: begin
            wr = 1'b1;
            rr = pc + 64'd4;
            npc = pc + immj;
          end
          OPC_JALR: begin
            wr = 1'b1;
            rr = pc + 64'd4;
            npc = (a + immi) & ~64'd1;
          end
          OPC_BRANCH: begin
            case (f3)
              3'd0:    take = a == b;
              3'd1:    take = a != b;
              3'd4:    take = lt_s;
              3'd5:    take = !lt_s;
              3'd6:    take = lt_u;
              3'd7:    take = !lt_u;
              default: take = 1'b0;
            endcase
            if (take) npc = pc + immb;
          end
          OPC_LOAD: begin
            if (f3 != 3'd7) begin
              addr = a + immi;
              res.mem_address = addr;
              case (f3[1:0])
                2'd0:    res.misaligned = 1'b0;
                2'd1:    res.misaligned = addr[0];
                2'd2:    res.misaligned = addr[1:0] != 2'b00;
                default: res.misaligned = addr[2:0] != 3'b000;
              endcase
            end
          end
          OPC_STORE: begin
            if (!f3[2]) begin
              addr = a + imms;
              res.mem_address = addr;
              case (f3[1:0])
                2'd0: begin
                  lane = addr[2:0];
                  res.mem_write_data = {56'd0, b[7:0]} << {lane, 3'b000};
                  res.byte_mask = 8'h01 << lane;
                end
                2'd1: begin
                  lane = {addr[2:1], 1'b0};
                  res.misaligned = addr[0];
                  res.mem_write_data = {48'd0, b[15:0]} << {lane, 3'b000};
                  res.byte_mask = 8'h03 << lane;
                end
                2'd2: begin
                  lane = {addr[2], 2'b00};
                  res.misaligned = addr[1:0] != 2'b00;
                  res.mem_write_data = {32'd0, b[31:0]} << {lane, 3'b000};
                  res.byte_mask = 8'h0f << lane;
                end
                default: begin
                  res.misaligned = addr[2:0] != 3'b000;
                  res.mem_write_data = b;
                  res.byte_mask = 8'hff;
                end
              endcase
              res.status = ST_STORE;
            end
          end
          default: ;
        endcase

        res.next_pc = npc;
        upd.pc = npc;
        if (opc == OPC_LOAD && f3 != 3'd7) begin
          res.status = ST_LOAD;
          upd.load_waiting = 1'b1;
          upd.load_dest = rd;
          upd.load_kind = f3;
          upd.load_byte_offset = addr[2:0];
        end else begin
          upd.retired = st.retired + 64'd1;
          res.retired_count = upd.retired;
          if (wr && rd != 5'd0) begin
            upd.reg_we = 1'b1;
            upd.reg_idx = rd;
            upd.reg_val = rr;
            res.dest_index = rd;
            res.dest_value = rr;
          end
        end
      end
    end
  end

endmodule

[src/rv64_regfile.sv]
// 32 x 64 register file with x0 hardwired to zero, two async read ports.
// Depends on rv64_pkg.
module rv64_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  ra,
  input  logic [4:0]  rb,
  output logic [63:0] qa,
  output logic [63:0] qb,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [63:0] wd
);
  import rv64_pkg::*;

  logic [63:0] regs [32];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else if (we && wa != 5'd0) begin
      regs[wa] <= wd;
    end
  end

  assign qa = (ra == 5'd0) ? 64'd0 : regs[ra];
  assign qb = (rb == 5'd0) ? 64'd0 : regs[rb];

endmodule

[src/rv64i_instruction_executor_unit.sv]
// RV64I executor top level: state registers, config port, output register.
// Depends on rv64_pkg, rv64_regfile and rv64_exec.
//
// Usage: an item on the in channel (valid/ready) is either an instruction
// word to execute at the current pc (op 0) or the doubleword returned for a
// pending load (op 1). Each effective transfer gives one result on the out
// channel in the next cycle. Items that the core ignores (load data with no load
// pending, an instruction while a load waits) produce no result.
// Throughput is one item per cycle while out_ready is high: state is updated
// at the accept edge, so the next instruction reads the new registers and pc
// immediately. The single output register is the only buffer; in_ready is
// high whenever that register is empty or being drained in the same cycle.
// A load takes two items: the request (status 1) and the data return.
// When out_ready stays low the result holds and input is stalled.
// Reset (rst, synchronous) clears all registers, pc and counters to zero and
// the config registers to their reset values. Config writes (cfg_we, cfg_index,
// cfg_data) take effect at once; writing start_pc also reloads the pc.
module rv64i_instruction_executor_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rv64_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rv64_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import rv64_pkg::*;

  arch_state_t  st;
  arch_update_t upd;
  out_item_t    res;
  logic [63:0]  rs1_val, rs2_val;
  logic         fire;

  assign in_ready = !out_valid || out_ready;
  assign fire = in_valid && in_ready;

  rv64_regfile u_rf (
    .clk(clk), .rst(rst),
    .ra(in_data.instruction_word[19:15]),
    .rb(in_data.instruction_word[24:20]),
    .qa(rs1_val), .qb(rs2_val),
    .we(fire && upd.valid && upd.reg_we),
    .wa(upd.reg_idx), .wd(upd.reg_val)
  );

  rv64_exec u_exec (
    .item(in_data), .st(st), .rs1_val(rs1_val), .rs2_val(rs2_val),
    .upd(upd), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire && upd.valid) begin
        st.pc <= upd.pc;
        st.retired <= upd.retired;
        st.load_waiting <= upd.load_waiting;
        st.load_dest <= upd.load_dest;
        st.load_kind <= upd.load_kind;
        st.load_byte_offset <= upd.load_byte_offset;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_PC: st.pc <= cfg_data;
          CFG_BP_EN:    st.bp_enable <= cfg_data[0];
          CFG_BP_ADDR:  st.bp_address <= cfg_data;
          default: ;
        endcase
      end
      if (fire && upd.valid) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && upd.valid) out_data <= res;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted input while output full");
  a_load_status: assert property (@(posedge clk) disable iff (rst)
    fire && upd.valid && !in_data.op && upd.load_waiting |=> st.load_waiting &&
      out_data.status == ST_LOAD)
    else $error("load request not recorded");
  a_ret_count: assert property (@(posedge clk) disable iff (rst)
    fire && upd.valid && in_data.op |=> st.retired == $past(st.retired) + 64'd1)
    else $error("load return did not retire");

endmodule

[tb/sv/rv64i_instruction_executor_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the RV64I executor: directed rows, then random programs.
// Results are checked against an in-bench model of the core; depends on rv64_pkg.
module rv64i_instruction_executor_unit_tb;
  import rv64_pkg::*;

  localparam int ITEM_TARGET = 1450;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] LK_B    = 3'd0;
  localparam logic [2:0] LK_H    = 3'd1;
  localparam logic [2:0] LK_W    = 3'd2;
  localparam logic [2:0] LK_D    = 3'd3;
  localparam logic [2:0] LK_BU   = 3'd4;
  localparam logic [2:0] LK_HU   = 3'd5;
  localparam logic [2:0] LK_WU   = 3'd6;
  localparam logic [2:0] LK_NONE = 3'd7;
  localparam logic [31:0] INSN_ECALL = 32'h0000_0073;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  rv64i_instruction_executor_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Architectural state of the core as the bench models it.
  logic [63:0] gpr [32];
  logic [63:0] cur_pc, retired, bp_addr;
  logic        bp_en;
  logic        ld_wait;
  logic [4:0]  ld_dest;
  logic [2:0]  ld_kind, ld_off;

  out_item_t pending_results [$];
  int  errors = 0;
  int  done_items = 0;
  bit  idling = 1'b1;
  bit  hold_req = 1'b0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic out_item_t mk_res(logic [2:0] st, logic [63:0] addr, logic [63:0] wd,
                                       logic [7:0] mask, logic [63:0] npc, logic [4:0] di,
                                       logic [63:0] dv, logic mis, logic [63:0] ret);
    out_item_t r;
    r.status = st; r.mem_address = addr; r.mem_write_data = wd; r.byte_mask = mask;
    r.next_pc = npc; r.dest_index = di; r.dest_value = dv; r.misaligned = mis;
    r.retired_count = ret;
    return r;
  endfunction

  function automatic void reset_core_model();
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    cur_pc = '0; retired = '0; bp_en = 1'b0; bp_addr = '0;
    ld_wait = 1'b0; ld_dest = '0; ld_kind = '0; ld_off = '0;
  endfunction

  // Executes one item on the model; returns 1 when the core produces a result.
  function automatic bit exec_step(input in_item_t it, output out_item_t r);
    logic [31:0] w, lo, w32;
    logic [63:0] a, b, immi, imms, immu, immb, immj, res, t, addr, dm, npc;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3, lane;
    logic [5:0]  sh;
    logic [3:0]  nbytes;
    logic [15:0] m16;
    bit          wr, take;
    r = '0;
    w = it.instruction_word;
    if (it.op) begin
      if (!ld_wait) return 1'b0;
      case (ld_kind)
        LK_B:  begin t = it.load_data >> {ld_off, 3'b000}; res = {{56{t[7]}}, t[7:0]}; end
        LK_H:  begin
          t = it.load_data >> {ld_off & 3'b110, 3'b000}; res = {{48{t[15]}}, t[15:0]};
        end
        LK_W:  begin
          t = it.load_data >> {ld_off & 3'b100, 3'b000}; res = {{32{t[31]}}, t[31:0]};
        end
        LK_BU: begin t = it.load_data >> {ld_off, 3'b000}; res = {56'd0, t[7:0]}; end
        LK_HU: begin t = it.load_data >> {ld_off & 3'b110, 3'b000}; res = {48'd0, t[15:0]}; end
        LK_WU: begin t = it.load_data >> {ld_off & 3'b100, 3'b000}; res = {32'd0, t[31:0]}; end
        default: res = it.load_data;
      endcase
      ld_wait = 1'b0;
      if (ld_dest != 0) begin
        gpr[ld_dest] = res; r.dest_index = ld_dest; r.dest_value = res;
      end
      retired = retired + 1;
      r.next_pc = cur_pc;
      r.retired_count = retired;
      return 1'b1;
    end
    if (ld_wait) return 1'b0;
    if (cur_pc[1:0] != 0 || (it.check_breakpoint && bp_en && cur_pc == bp_addr)) begin
      r.status = (cur_pc[1:0] != 0) ? ST_PC_MIS : ST_BREAK;
      r.next_pc = cur_pc;
      r.retired_count = retired;
      return 1'b1;
    end
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12];
    a = gpr[w[19:15]]; b = gpr[w[24:20]];
    immi = {{52{w[31]}}, w[31:20]};
    imms = {{52{w[31]}}, w[31:25], w[11:7]};
    immu = {{32{w[31]}}, w[31:12], 12'd0};
    immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    npc = cur_pc + 4;
    wr = 1'b0; res = '0;
    case (opc)
      OPC_OPIMM, OPC_OP: begin
        wr = 1'b1;
        if (opc == OPC_OPIMM) begin
          sh = w[25:20]; t = immi;
        end else begin
          sh = b[5:0]; t = b;
        end
        case (f3)
          F3_ADD:  res = (opc == OPC_OP && w[30]) ? a - b : a + t;
          F3_SLL:  res = a << sh;
          F3_SLT:  res = ($signed(a) < $signed(t)) ? 64'd1 : 64'd0;
          F3_SLTU: res = (a < t) ? 64'd1 : 64'd0;
          F3_XOR:  res = a ^ t;
          F3_SR:   if (w[30]) res = $signed(a) >>> sh; else res = a >> sh;
          F3_OR:   res = a | t;
          default: res = a & t;
        endcase
      end
      OPC_OPIMMW, OPC_OPW: begin
        sh = (opc == OPC_OPIMMW) ? {1'b0, w[24:20]} : {1'b0, b[4:0]};
        lo = a[31:0];
        wr = 1'b1;
        if (f3 == F3_ADD) begin
          t = (opc == OPC_OPIMMW) ? a + immi : (w[30] ? a - b : a + b);
          res = {{32{t[31]}}, t[31:0]};
        end else if (f3 == F3_SLL) begin
          w32 = lo << sh[4:0];
          res = {{32{w32[31]}}, w32};
        end else if (f3 == F3_SR) begin
          if (w[30]) w32 = $signed(lo) >>> sh[4:0];
          else w32 = lo >> sh[4:0];
          res = {{32{w32[31]}}, w32};
        end else begin
          wr = 1'b0;
        end
      end
      OPC_LUI:   begin wr = 1'b1; res = immu; end
      OPC_AUIPC: begin wr = 1'b1; res = cur_pc + immu; end
      OPC_JAL:   begin wr = 1'b1; res = cur_pc + 4; npc = cur_pc + immj; end
      OPC_JALR:  begin wr = 1'b1; res = cur_pc + 4; npc = (a + immi) & ~64'd1; end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: take = 1'b0;
        endcase
        if (take) npc = cur_pc + immb;
      end
      OPC_LOAD: begin
        if (f3 != LK_NONE) begin
          addr = a + immi;
          r.status = ST_LOAD;
          r.mem_address = addr;
          r.misaligned = (f3[1:0] == 2'd1 && addr[0]) || (f3[1:0] == 2'd2 && addr[1:0] != 0)
                         || (f3[1:0] == 2'd3 && addr[2:0] != 0);
          ld_wait = 1'b1; ld_dest = rd; ld_kind = f3; ld_off = addr[2:0];
          cur_pc = npc;
          r.next_pc = npc;
          r.retired_count = retired;
          return 1'b1;
        end
      end
      OPC_STORE: begin
        if (!f3[2]) begin
          addr = a + imms;
          nbytes = 4'd1 << f3[1:0];
          lane = addr[2:0] & ~3'(nbytes - 1);
          dm = (nbytes == 8) ? '1 : ((64'd1 << {nbytes, 3'b000}) - 1);
          m16 = ((16'd1 << nbytes) - 16'd1) << lane;
          r.status = ST_STORE;
          r.mem_address = addr;
          r.mem_write_data = (b & dm) << {lane, 3'b000};
          r.byte_mask = m16[7:0];
          r.misaligned = (addr[2:0] & 3'(nbytes - 1)) != 0;
        end
      end
      default: ;
    endcase
    if (wr && rd != 0) begin
      gpr[rd] = res; r.dest_index = rd; r.dest_value = res;
    end
    cur_pc = npc;
    retired = retired + 1;
    r.next_pc = npc;
    r.retired_count = retired;
    return 1'b1;
  endfunction

  function automatic void compare_result(out_item_t got, out_item_t exp_r);
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
    end
    if (got.mem_address !== exp_r.mem_address) begin
      $error("mem_address: expected %h, got %h", exp_r.mem_address, got.mem_address); errors++;
    end
    if (got.mem_write_data !== exp_r.mem_write_data) begin
      $error("mem_write_data: expected %h, got %h", exp_r.mem_write_data, got.mem_write_data);
      errors++;
    end
    if (got.byte_mask !== exp_r.byte_mask) begin
      $error("byte_mask: expected %h, got %h", exp_r.byte_mask, got.byte_mask); errors++;
    end
    if (got.next_pc !== exp_r.next_pc) begin
      $error("next_pc: expected %h, got %h", exp_r.next_pc, got.next_pc); errors++;
    end
    if (got.dest_index !== exp_r.dest_index) begin
      $error("dest_index: expected %0d, got %0d", exp_r.dest_index, got.dest_index); errors++;
    end
    if (got.dest_value !== exp_r.dest_value) begin
      $error("dest_value: expected %h, got %h", exp_r.dest_value, got.dest_value); errors++;
    end
    if (got.misaligned !== exp_r.misaligned) begin
      $error("misaligned: expected %b, got %b", exp_r.misaligned, got.misaligned); errors++;
    end
    if (got.retired_count !== exp_r.retired_count) begin
      $error("retired_count: expected %0d, got %0d", exp_r.retired_count, got.retired_count);
      errors++;
    end
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  // Offsets are mostly word multiples so the program keeps running; a few land on halfwords.
  function automatic logic [31:0] random_insn();
    int sel;
    logic [12:0] boff;
    logic [20:0] joff;
    sel = $urandom_range(0, 99);
    if (sel < 20)
      return enc_i(12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OPC_OPIMM);
    if (sel < 35)
      return enc_r(7'($urandom), pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OPC_OP);
    if (sel < 45)
      return enc_r(7'($urandom), pick_reg(), pick_reg(), 3'($urandom), pick_reg(),
                   $urandom_range(0, 1) ? OPC_OPW : OPC_OPIMMW);
    if (sel < 50)
      return {20'($urandom), pick_reg(), $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC};
    if (sel < 60) begin
      boff = ($urandom_range(0, 15) == 0) ? 13'($urandom) : 13'(($urandom_range(0, 32) - 16) * 4);
      return enc_b(boff, pick_reg(), pick_reg(), 3'($urandom));
    end
    if (sel < 62) begin
      joff = ($urandom_range(0, 7) == 0) ? 21'($urandom) : 21'(($urandom_range(0, 32) - 16) * 4);
      return enc_j(joff, pick_reg());
    end
    if (sel < 64)
      return enc_i(($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, 255) * 4),
                   ($urandom_range(0, 3) == 0) ? pick_reg() : 5'd0, F3_ADD, pick_reg(), OPC_JALR);
    if (sel < 80)
      return enc_i(12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OPC_LOAD);
    if (sel < 92)
      return enc_s(12'($urandom), pick_reg(), pick_reg(), 3'($urandom));
    return $urandom;
  endfunction

  // Offers one item, waits for the transfer and records what the core should answer.
  task automatic send(input in_item_t it, input bit typed, input out_item_t typed_res,
                      output bit produced);
    out_item_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    produced = exec_step(it, r);
    if (produced) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic maybe_gap();
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The caller lowers cfg_we once after its last write.
  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_START_PC: cur_pc = val;
      CFG_BP_EN:    bp_en = val[0];
      CFG_BP_ADDR:  bp_addr = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t insn_item(logic [31:0] w, logic chk);
    in_item_t it;
    it.op = 1'b0; it.instruction_word = w; it.check_breakpoint = chk;
    it.load_data = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t data_item(logic [63:0] d);
    in_item_t it;
    it.op = 1'b1; it.instruction_word = $urandom; it.check_breakpoint = 1'($urandom);
    it.load_data = d;
    return it;
  endfunction

  task automatic run_directed();
    dir_row_t rows [$];
    out_item_t none;
    bit got;
    none = '0;
    rows.push_back('{insn_item(enc_i(12'hfff, 5'd0, F3_ADD, 5'd1, OPC_OPIMM), 1'b0), 1'b1,
                     mk_res(ST_RETIRED, '0, '0, '0, 64'd4, 5'd1, '1, 1'b0, 64'd1)});
    // Load data with nothing pending is dropped.
    rows.push_back('{data_item(64'h1234), 1'b0, none});
    rows.push_back('{insn_item({20'h80000, 5'd2, OPC_LUI}, 1'b0), 1'b1,
                     mk_res(ST_RETIRED, '0, '0, '0, 64'd8, 5'd2, 64'hffff_ffff_8000_0000,
                            1'b0, 64'd2)});
    rows.push_back('{insn_item(enc_s(12'd3, 5'd1, 5'd0, LK_W), 1'b0), 1'b1,
                     mk_res(ST_STORE, 64'd3, 64'h0000_0000_ffff_ffff, 8'h0f, 64'd12, 5'd0,
                            64'd0, 1'b1, 64'd3)});
    rows.push_back('{insn_item(enc_i(12'd0, 5'd2, LK_D, 5'd7, OPC_LOAD), 1'b0), 1'b1,
                     mk_res(ST_LOAD, 64'hffff_ffff_8000_0000, '0, '0, 64'd16, 5'd0, 64'd0,
                            1'b0, 64'd3)});
    // An instruction offered while the load waits is dropped.
    rows.push_back('{insn_item(enc_i(12'd5, 5'd0, F3_ADD, 5'd3, OPC_OPIMM), 1'b0), 1'b0, none});
    rows.push_back('{data_item(64'h8877_6655_4433_2211), 1'b1,
                     mk_res(ST_RETIRED, '0, '0, '0, 64'd16, 5'd7, 64'h8877_6655_4433_2211,
                            1'b0, 64'd4)});
    rows.push_back('{insn_item(enc_r(7'h00, 5'd2, 5'd1, F3_SLT, 5'd3, OPC_OP), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_r(7'h00, 5'd2, 5'd1, F3_SLTU, 5'd4, OPC_OP), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_i({6'b010000, 6'd63}, 5'd2, F3_SR, 5'd5, OPC_OPIMM), 1'b0),
                     1'b0, none});
    rows.push_back('{insn_item(enc_r(7'h20, 5'd1, 5'd2, F3_ADD, 5'd8, OPC_OP), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_r(7'h20, 5'd1, 5'd2, F3_SR, 5'd9, OPC_OP), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_r(7'h20, 5'd1, 5'd2, F3_SR, 5'd11, OPC_OPW), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_i(12'd31, 5'd1, F3_SLL, 5'd12, OPC_OPIMMW), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_r(7'h00, 5'd1, 5'd2, F3_SLT, 5'd13, OPC_OPW), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_i(12'd7, 5'd0, LK_B, 5'd13, OPC_LOAD), 1'b0), 1'b0, none});
    rows.push_back('{data_item(64'h80ff_0000_0000_0000), 1'b0, none});
    rows.push_back('{insn_item(enc_i(12'd1, 5'd2, LK_HU, 5'd14, OPC_LOAD), 1'b0), 1'b0, none});
    rows.push_back('{data_item('1), 1'b0, none});
    rows.push_back('{insn_item(enc_s(12'd4, 5'd7, 5'd0, LK_D), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_s(12'd0, 5'd7, 5'd0, 3'd5), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_b(-13'sd8, 5'd1, 5'd2, F3_BLT), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_b(13'd8, 5'd1, 5'd0, F3_BGEU), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(INSN_ECALL, 1'b1), 1'b0, none});
    rows.push_back('{insn_item(32'd0, 1'b0), 1'b0, none});
    rows.push_back('{insn_item(enc_j(21'h100000, 5'd1), 1'b0), 1'b0, none});
    // A jump to a halfword address halts the following instruction.
    rows.push_back('{insn_item(enc_i(12'd2, 5'd0, F3_ADD, 5'd15, OPC_JALR), 1'b0), 1'b0, none});
    rows.push_back('{insn_item(32'hffff_ffff, 1'b1), 1'b0, none});
    foreach (rows[i]) begin
      send(rows[i].item, rows[i].typed, rows[i].res, got);
      if (got) done_items++;
    end
  endtask

  task automatic run_phase(input int n);
    in_item_t it;
    out_item_t none;
    bit got;
    int stuck;
    none = '0;
    stuck = 0;
    for (int k = 0; k < n; k++) begin
      if (cur_pc[1:0] != 0) stuck++;
      if (stuck > 3) break;
      if (ld_wait)
        it = ($urandom_range(0, 9) == 0) ? insn_item($urandom, 1'($urandom))
                                         : data_item({$urandom, $urandom});
      else if ($urandom_range(0, 19) == 0)
        it = data_item({$urandom, $urandom});
      else
        it = insn_item(random_insn(), 1'($urandom));
      send(it, 1'b0, none, got);
      if (got) done_items++;
      maybe_gap();
    end
    if (ld_wait) begin
      send(data_item({$urandom, $urandom}), 1'b0, none, got);
      done_items++;
    end
  endtask

  initial begin : stimulus
    int phase;
    logic [63:0] spc;
    phase = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_START_PC;
    cfg_data <= '0;
    reset_core_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    while (done_items < ITEM_TARGET) begin
      phase++;
      settle();
      case ($urandom_range(0, 5))
        0: spc = '0;
        1: spc = 64'hffff_ffff_ffff_fffc;
        2: spc = '1;
        default: spc = {$urandom, $urandom} & ~64'd3;
      endcase
      write_cfg(CFG_START_PC, spc);
      write_cfg(CFG_BP_EN, 64'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_BP_ADDR, '0);
        1: write_cfg(CFG_BP_ADDR, '1);
        default: write_cfg(CFG_BP_ADDR, spc + 64'($urandom_range(0, 5) * 4));
      endcase
      cfg_we <= 1'b0;
      if (phase == 3) hold_req = 1'b1;
      idling = (done_items < ITEM_TARGET - 200) && ($urandom_range(0, 3) != 0);
      run_phase($urandom_range(30, 120));
    end
    idling = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Result side: checks each transfer and stalls in short bursts or one long stretch.
  initial begin : result_side
    int hold_left;
    out_item_t exp_r;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result outstanding");
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          compare_result(out_data, exp_r);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
